/* design/fhd_pkg.sv */
// Package for the file header deframer: field sizes, phase codes, byte kinds
// and error codes. No dependencies.
package fhd_pkg;

    localparam int NAME_BYTES  = 128;
    localparam int SIZE_DIGITS = 10;

    localparam int IDX_MAX = (NAME_BYTES > SIZE_DIGITS) ? NAME_BYTES : SIZE_DIGITS;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);

    localparam int SIZE_W = 34;
    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [SIZE_W-1:0] size_t;

    // Phase codes
    localparam logic [2:0] PH_NAME    = 3'd0;
    localparam logic [2:0] PH_SIZE    = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;

    // Byte kinds
    localparam logic [2:0] KIND_NAME    = 3'd0;
    localparam logic [2:0] KIND_PAD     = 3'd1;
    localparam logic [2:0] KIND_SIZE    = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD = 3'd3;
    localparam logic [2:0] KIND_IGNORED = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_PAD  = 2'd1;
    localparam logic [1:0] ERR_SIZE = 2'd2;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

/* design/file_header_deframer_unit.sv */
// File header deframer top level: parses a name/size header from a byte
// stream, then counts the payload. Depends on fhd_pkg.
//
// The result of an accepted input is registered and shows on m_valid next cycle.
// Throughput: one byte per cycle unless m_ready stalls; each byte updates phase,
// index, size accumulator and payload counter in a single combinational step.
// Reset (aresetn low, synchronous): phase returns to the name field, all
// counters and the sticky error clear, and the result register empties.
module file_header_deframer_unit
    import fhd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_in_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic [2:0]        m_byte_kind,
    output logic              m_last_payload,
    output logic              m_header_done,
    output logic [SIZE_W-1:0] m_file_size,
    output logic [1:0]        m_error_code
);

    // Parser state
    logic [2:0] phase_reg,     phase_next;
    idx_t       field_idx_reg, field_idx_next;
    logic       zero_seen_reg, zero_seen_next;
    logic       digit_seen_reg, digit_seen_next;
    size_t      size_acc_reg,  size_acc_next;
    size_t      pay_cnt_reg,   pay_cnt_next;
    logic [1:0] err_reg,       err_next;

    // Result register
    logic             m_valid_reg;
    logic [7:0]       byte_reg;
    logic [2:0]       kind_reg,  kind_next;
    logic             last_reg,  last_next;
    logic             done_reg,  done_next;
    size_t            fsize_reg, fsize_next;
    logic [1:0]       code_reg;

    logic             accept;
    logic             is_digit;
    logic [SIZE_W+3:0] acc_wide;
    size_t            acc_step;
    size_t            pay_cnt_inc;

    // Take a new transaction whenever the result register is free or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_digit = (s_in_byte >= CH_ZERO) && (s_in_byte <= CH_NINE);

    // acc*10 + digit, saturated to the size width
    assign acc_wide = ({4'b0, size_acc_reg} << 3) + ({4'b0, size_acc_reg} << 1)
                    + {{SIZE_W{1'b0}}, s_in_byte[3:0]};
    assign acc_step = (acc_wide[SIZE_W+3:SIZE_W] != 4'b0) ? SIZE_MAX
                                                           : acc_wide[SIZE_W-1:0];

    assign pay_cnt_inc = pay_cnt_reg + size_t'(1);

    always_comb begin
        phase_next      = phase_reg;
        field_idx_next  = field_idx_reg;
        zero_seen_next  = zero_seen_reg;
        digit_seen_next = digit_seen_reg;
        size_acc_next   = size_acc_reg;
        pay_cnt_next    = pay_cnt_reg;
        err_next        = err_reg;
        kind_next       = KIND_IGNORED;
        last_next       = 1'b0;
        done_next       = 1'b0;
        fsize_next      = '0;

        case (phase_reg)
            PH_NAME: begin
                if (s_in_byte != CH_NUL && zero_seen_reg) begin
                    // Non-zero byte after padding started: bad padding.
                    kind_next  = KIND_PAD;
                    err_next   = ERR_PAD;
                    phase_next = PH_ERROR;
                end else begin
                    if (s_in_byte == CH_NUL) begin
                        zero_seen_next = 1'b1;
                        kind_next      = KIND_PAD;
                    end else begin
                        kind_next = KIND_NAME;
                    end
                    if (field_idx_reg == idx_t'(NAME_BYTES - 1)) begin
                        field_idx_next = '0;
                        phase_next     = PH_SIZE;
                    end else begin
                        field_idx_next = field_idx_reg + idx_t'(1);
                    end
                end
            end
            PH_SIZE: begin
                kind_next = KIND_SIZE;
                if (!(s_in_byte == CH_SPACE && !digit_seen_reg) && !is_digit) begin
                    // Anything but a leading space or a digit is fatal.
                    digit_seen_next = 1'b1;
                    err_next        = ERR_SIZE;
                    phase_next      = PH_ERROR;
                end else begin
                    if (!(s_in_byte == CH_SPACE && !digit_seen_reg)) begin
                        digit_seen_next = 1'b1;
                        size_acc_next   = acc_step;
                    end
                    if (field_idx_reg == idx_t'(SIZE_DIGITS - 1)) begin
                        // Header complete: publish size and start the payload.
                        field_idx_next = '0;
                        done_next      = 1'b1;
                        fsize_next     = size_acc_next;
                        pay_cnt_next   = '0;
                        if (size_acc_next == '0) begin
                            last_next  = 1'b1;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end else begin
                        field_idx_next = field_idx_reg + idx_t'(1);
                    end
                end
            end
            PH_PAYLOAD: begin
                kind_next    = KIND_PAYLOAD;
                fsize_next   = size_acc_reg;
                pay_cnt_next = pay_cnt_inc;
                if (pay_cnt_inc == size_acc_reg) begin
                    last_next  = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
                // Drop excess bytes, keep reporting the size.
                fsize_next = size_acc_reg;
            end
            default: begin
                // Error: ignore everything until reset.
            end
        endcase
    end

    // Control state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_NAME;
            field_idx_reg  <= '0;
            zero_seen_reg  <= 1'b0;
            digit_seen_reg <= 1'b0;
            size_acc_reg   <= '0;
            pay_cnt_reg    <= '0;
            err_reg        <= ERR_NONE;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                field_idx_reg  <= field_idx_next;
                zero_seen_reg  <= zero_seen_next;
                digit_seen_reg <= digit_seen_next;
                size_acc_reg   <= size_acc_next;
                pay_cnt_reg    <= pay_cnt_next;
                err_reg        <= err_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    // Result payload: load on every accepted transaction, hold otherwise.
    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg  <= s_in_byte;
            kind_reg  <= kind_next;
            last_reg  <= last_next;
            done_reg  <= done_next;
            fsize_reg <= fsize_next;
            code_reg  <= err_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_byte_kind    = kind_reg;
    assign m_last_payload = last_reg;
    assign m_header_done  = done_reg;
    assign m_file_size    = fsize_reg;
    assign m_error_code   = code_reg;

    // Header completion is only ever reported on a size byte.
    a_done_on_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_header_done |-> m_byte_kind == KIND_SIZE)
        else $error("header_done on a non-size byte");

    // Last marker belongs to a payload byte or a zero-size header end.
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_payload |->
            (m_byte_kind == KIND_PAYLOAD) || (m_header_done && m_file_size == '0))
        else $error("last_payload on an unexpected byte");

    // Error phase always carries a nonzero sticky code.
    a_err_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_ERROR |-> err_reg != ERR_NONE)
        else $error("error phase without error code");

    // Once raised, the error code never changes until reset.
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != ERR_NONE |=> err_reg == $past(err_reg))
        else $error("sticky error changed");

    // Payload count never passes the decoded size.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> pay_cnt_reg < size_acc_reg)
        else $error("payload count overran size");

endmodule
